@@ design/doa_pkg.sv @@
package doa_pkg;

    // field widths fixed by the interface
    localparam int unsigned FracW   = 17;
    localparam int unsigned MarginW = 22;
    localparam int unsigned RelaxW  = 21;
    localparam int unsigned OffsetW = 20;
    localparam int unsigned StepW   = 16;
    localparam int unsigned RunW    = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 21;

    // margin limits and the no-margin sentinel
    localparam logic signed [MarginW-1:0] MarginMax = 22'sh1FFFFF;
    localparam logic signed [MarginW-1:0] MarginMin = 22'sh200001;
    localparam logic signed [MarginW-1:0] NoMargin  = 22'sh200000;

    localparam logic [RunW-1:0] RunMax = 8'hFF;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgMissThreshold = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgLateThreshold = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgClimbFrames   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgMaxOffset     = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgClimbStep     = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgRelaxStep     = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgRelaxMargin   = 3'd6;

    // configuration reset values
    localparam logic [FracW-1:0]         RstMissThreshold = 17'd3277;
    localparam logic [FracW-1:0]         RstLateThreshold = 17'd655;
    localparam logic [RunW-1:0]          RstClimbFrames   = 8'd2;
    localparam logic [OffsetW-1:0]       RstMaxOffset     = 20'd20000;
    localparam logic [StepW-1:0]         RstClimbStep     = 16'd2000;
    localparam logic [StepW-1:0]         RstRelaxStep     = 16'd500;
    localparam logic signed [RelaxW-1:0] RstRelaxMargin   = 21'sd3000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_CLIMB,
        S_PUSH,
        S_SCAN,
        S_DRAIN,
        S_RELAX,
        S_DONE
    } t_state;

endpackage

@@ design/deadline_offset_adapter_unit.sv @@
// Deadline offset adapter. One item per frame carries the missed fraction, the late
// fraction (unsigned Q1.16) and the worst arrival margin; one result item per frame gives
// the deadline offset and whether it climbed (direction 0) or relaxed (direction 1).
// The input is stalled while an item is in work. An accepted item passes the classify,
// climb and push states and then the done state, which loads the result into the output
// register. When the window is full after the push and the offset is nonzero, the scan,
// drain and relax states come before done: the worst margin is found by scanning the
// margin window memory through its single read port, one entry per cycle. The next item
// can be taken in the cycle after the result is loaded; the done state holds while an
// earlier result stalls in the output register. The result sits in that output register,
// so the next item is taken while it waits downstream. Configuration writes land at once
// through the write port and are meant for idle periods.
module deadline_offset_adapter_unit #(
    parameter int unsigned WINDOW_FRAMES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [doa_pkg::CfgIdxW-1:0]           i_cfg_index,
    input  logic [doa_pkg::CfgDataW-1:0]          i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [doa_pkg::FracW-1:0]             i_missed_fraction,
    input  logic signed [doa_pkg::MarginW-1:0]    i_worst_margin_us,
    input  logic [doa_pkg::FracW-1:0]             i_tardy_fraction,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [doa_pkg::OffsetW-1:0]           o_deadline_offset_us,
    output logic                                  o_offset_moved,
    output logic                                  o_move_direction
);

    localparam int unsigned AddrW = $clog2(WINDOW_FRAMES);
    localparam int unsigned FillW = $clog2(WINDOW_FRAMES + 1);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(WINDOW_FRAMES - 1);
    localparam logic [FillW-1:0] FullFill = FillW'(WINDOW_FRAMES);
    localparam logic [FillW-1:0] NearFull = FillW'(WINDOW_FRAMES - 1);

    // configuration registers
    logic [doa_pkg::FracW-1:0]          r_miss_threshold;
    logic [doa_pkg::FracW-1:0]          r_late_threshold;
    logic [doa_pkg::RunW-1:0]           r_climb_frames;
    logic [doa_pkg::OffsetW-1:0]        r_max_offset;
    logic [doa_pkg::StepW-1:0]          r_climb_step;
    logic [doa_pkg::StepW-1:0]          r_relax_step;
    logic signed [doa_pkg::RelaxW-1:0]  r_relax_margin;

    // adapter state
    doa_pkg::t_state                    r_state;
    doa_pkg::t_state                    n_state;
    logic [doa_pkg::OffsetW-1:0]        r_offset;
    logic [doa_pkg::RunW-1:0]           r_bad_run;
    logic [FillW-1:0]                   r_fill;   // number of window entries, saturating at WINDOW_FRAMES
    logic [AddrW-1:0]                   r_head;

    // captured item and per-item flags
    logic [doa_pkg::FracW-1:0]          r_missed;
    logic [doa_pkg::FracW-1:0]          r_late;
    logic signed [doa_pkg::MarginW-1:0] r_margin;
    logic                               r_climb;
    logic                               r_moved;
    logic                               r_dir;

    // scan state
    logic signed [doa_pkg::MarginW-1:0] r_window [WINDOW_FRAMES];
    logic [AddrW-1:0]                   r_idx;
    logic signed [doa_pkg::MarginW-1:0] r_rd_data;
    logic                               r_rd_vld;
    logic signed [doa_pkg::MarginW-1:0] r_worst;

    // output register
    logic                               r_out_valid;
    logic [doa_pkg::OffsetW-1:0]        r_out_offset;
    logic                               r_out_moved;
    logic                               r_out_dir;

    // decoded controls
    logic                               in_accept;
    logic                               rd_en;
    logic                               out_free;
    logic                               out_load;

    // classify datapath
    logic                               is_bad;
    logic [doa_pkg::RunW-1:0]           run_inc;

    // climb datapath
    logic [doa_pkg::OffsetW:0]          climb_sum;
    logic [doa_pkg::OffsetW-1:0]        climb_offset;

    // relax datapath
    logic [doa_pkg::OffsetW:0]          relax_diff;
    logic [doa_pkg::OffsetW-1:0]        relax_offset;
    logic                               relax_ok;

    // push datapath
    logic signed [doa_pkg::MarginW-1:0] push_value;
    logic [AddrW-1:0]                   head_inc;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_threshold <= doa_pkg::RstMissThreshold;
            r_late_threshold <= doa_pkg::RstLateThreshold;
            r_climb_frames   <= doa_pkg::RstClimbFrames;
            r_max_offset     <= doa_pkg::RstMaxOffset;
            r_climb_step     <= doa_pkg::RstClimbStep;
            r_relax_step     <= doa_pkg::RstRelaxStep;
            r_relax_margin   <= doa_pkg::RstRelaxMargin;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                doa_pkg::CfgMissThreshold: begin
                    r_miss_threshold <= i_cfg_data[doa_pkg::FracW-1:0];
                end
                doa_pkg::CfgLateThreshold: begin
                    r_late_threshold <= i_cfg_data[doa_pkg::FracW-1:0];
                end
                doa_pkg::CfgClimbFrames: begin
                    r_climb_frames <= i_cfg_data[doa_pkg::RunW-1:0];
                end
                doa_pkg::CfgMaxOffset: begin
                    r_max_offset <= i_cfg_data[doa_pkg::OffsetW-1:0];
                end
                doa_pkg::CfgClimbStep: begin
                    r_climb_step <= i_cfg_data[doa_pkg::StepW-1:0];
                end
                doa_pkg::CfgRelaxStep: begin
                    r_relax_step <= i_cfg_data[doa_pkg::StepW-1:0];
                end
                doa_pkg::CfgRelaxMargin: begin
                    r_relax_margin <= $signed(i_cfg_data[doa_pkg::RelaxW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            doa_pkg::S_IDLE: begin
                if (i_valid) n_state = doa_pkg::S_CLASSIFY;
            end
            doa_pkg::S_CLASSIFY: n_state = doa_pkg::S_CLIMB;
            doa_pkg::S_CLIMB:    n_state = doa_pkg::S_PUSH;
            doa_pkg::S_PUSH: begin
                if (r_offset != '0 && r_fill >= NearFull) n_state = doa_pkg::S_SCAN;
                else                                      n_state = doa_pkg::S_DONE;
            end
            doa_pkg::S_SCAN: begin
                if (r_idx == LastAddr) n_state = doa_pkg::S_DRAIN;
            end
            doa_pkg::S_DRAIN: n_state = doa_pkg::S_RELAX;
            doa_pkg::S_RELAX: n_state = doa_pkg::S_DONE;
            doa_pkg::S_DONE: begin
                if (out_free) n_state = doa_pkg::S_IDLE;
            end
            default: n_state = doa_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall   = (r_state != doa_pkg::S_IDLE);
        in_accept = i_valid && (r_state == doa_pkg::S_IDLE);
        rd_en     = (r_state == doa_pkg::S_SCAN);
        out_free  = !r_out_valid || !i_stall;
        out_load  = (r_state == doa_pkg::S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= doa_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // classify: bad frame test and saturating run count
    always_comb begin
        is_bad  = (r_missed > r_miss_threshold) || (r_late > r_late_threshold);
        run_inc = (r_bad_run < doa_pkg::RunMax) ? r_bad_run + 1'b1 : r_bad_run;
    end

    // climb and relax arithmetic
    always_comb begin
        climb_sum    = {1'b0, r_offset} + {{(doa_pkg::OffsetW + 1 - doa_pkg::StepW){1'b0}},
                                           r_climb_step};
        climb_offset = (climb_sum > {1'b0, r_max_offset}) ? r_max_offset
                                                          : climb_sum[doa_pkg::OffsetW-1:0];
        relax_diff   = {1'b0, r_offset} - {{(doa_pkg::OffsetW + 1 - doa_pkg::StepW){1'b0}},
                                           r_relax_step};
        relax_offset = relax_diff[doa_pkg::OffsetW] ? '0 : relax_diff[doa_pkg::OffsetW-1:0];
        relax_ok     = (r_worst >= doa_pkg::MarginW'(r_relax_margin));
    end

    // window entry for this frame and head advance
    always_comb begin
        push_value = (r_missed != '0) ? doa_pkg::NoMargin : r_margin;
        head_inc   = (r_head == LastAddr) ? '0 : r_head + 1'b1;
    end

    // control state of the adapter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_bad_run <= '0;
            r_fill    <= '0;
            r_head    <= '0;
            r_climb   <= 1'b0;
            r_moved   <= 1'b0;
            r_dir     <= 1'b0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            unique case (r_state)
                doa_pkg::S_IDLE: begin
                    r_moved <= 1'b0;
                    r_dir   <= 1'b0;
                end
                doa_pkg::S_CLASSIFY: begin
                    if (is_bad) begin
                        r_bad_run <= run_inc;
                        r_climb   <= (run_inc >= r_climb_frames) && (r_offset < r_max_offset);
                    end else begin
                        r_bad_run <= '0;
                        r_climb   <= 1'b0;
                    end
                end
                doa_pkg::S_CLIMB: begin
                    if (r_climb) begin
                        r_offset  <= climb_offset;
                        r_bad_run <= '0;
                        r_moved   <= 1'b1;
                        r_dir     <= 1'b0;
                        r_fill    <= '0;
                        r_head    <= '0;
                    end
                end
                doa_pkg::S_PUSH: begin
                    r_head <= head_inc;
                    if (r_fill < FullFill) r_fill <= r_fill + 1'b1;
                    r_idx <= '0;
                end
                doa_pkg::S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                end
                doa_pkg::S_DRAIN: begin
                end
                doa_pkg::S_RELAX: begin
                    if (r_fill == FullFill && relax_ok) begin
                        r_offset <= relax_offset;
                        r_moved  <= 1'b1;
                        r_dir    <= 1'b1;
                        r_fill   <= '0;
                        r_head   <= '0;
                    end
                end
                doa_pkg::S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // item capture with margin saturation
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_missed <= i_missed_fraction;
            r_late   <= i_tardy_fraction;
            r_margin <= (i_worst_margin_us == doa_pkg::NoMargin) ? doa_pkg::MarginMin
                                                                 : i_worst_margin_us;
        end
    end

    // margin window memory
    always_ff @(posedge i_clk) begin
        if (r_state == doa_pkg::S_PUSH) r_window[r_head] <= push_value;
        if (rd_en) r_rd_data <= r_window[r_idx];
    end

    // running minimum over the window
    always_ff @(posedge i_clk) begin
        if (r_state == doa_pkg::S_PUSH) begin
            r_worst <= doa_pkg::MarginMax;
        end else if (r_rd_vld && r_rd_data < r_worst) begin
            r_worst <= r_rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_offset <= r_offset;
            r_out_moved  <= r_moved;
            r_out_dir    <= r_moved & r_dir;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_deadline_offset_us = r_out_offset;
    assign o_offset_moved       = r_out_moved;
    assign o_move_direction     = r_out_dir;

endmodule
